[sv/top_k_score_selector_top_assert.svh]
// ----------------------------------------------------------------------------
// top_k_score_selector_top_assert.svh
// Assertion macros shared by the top-k selector modules.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SCORE_SELECTOR_TOP_ASSERT_SVH
`define TOP_K_SCORE_SELECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Plain property, clocked on i_clk, off during reset.
`define TKSS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("%m: check failed");

// Implication form.
`define TKSS_IMPLY(lbl, ante, cons) \
    `TKSS_ASSERT(lbl, (ante) |-> (cons))

// Next-cycle implication form.
`define TKSS_IMPLY_NEXT(lbl, ante, cons) \
    `TKSS_ASSERT(lbl, (ante) |=> (cons))

`else

`define TKSS_ASSERT(lbl, prop)
`define TKSS_IMPLY(lbl, ante, cons)
`define TKSS_IMPLY_NEXT(lbl, ante, cons)

`endif

`endif

[sv/tkss_pkg.sv]
// ----------------------------------------------------------------------------
// tkss_pkg
// Shared widths, defaults and reset values of the top-k score selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tkss_pkg;

    localparam int SCORE_W         = 32;   // signed Q16.16
    localparam int CFG_W           = 4;    // top_count register width
    localparam int MAX_TOP_DEF     = 8;
    localparam int MAX_CLASSES_DEF = 1024;

    localparam logic [CFG_W-1:0] TOP_COUNT_RST = CFG_W'(5);

endpackage

[sv/tkss_sorter.sv]
// ----------------------------------------------------------------------------
// tkss_sorter
// Input register plus a sorted list of the best MAX_TOP (score, index)
// entries. Each registered score is inserted by a parallel compare against
// all entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "top_k_score_selector_top_assert.svh"

module tkss_sorter #(
    parameter int MAX_TOP     = tkss_pkg::MAX_TOP_DEF,
    parameter int MAX_CLASSES = tkss_pkg::MAX_CLASSES_DEF,
    localparam int IDX_W      = $clog2(MAX_CLASSES)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               i_s_valid,
    output logic                               o_s_ready,
    input  logic signed [tkss_pkg::SCORE_W-1:0] i_s_score,
    input  logic                               i_s_last,
    // snapshot toward the result buffer
    input  logic                               i_load_ok,
    output logic                               o_snap_valid,
    output logic [MAX_TOP-1:0]                 o_snap_vld,
    output logic signed [tkss_pkg::SCORE_W-1:0] o_snap_score [MAX_TOP],
    output logic [IDX_W-1:0]                   o_snap_idx   [MAX_TOP]
);

    import tkss_pkg::*;

    localparam int POS_W = $clog2(MAX_CLASSES + 1);

    logic                      r_in_valid;
    logic signed [SCORE_W-1:0] r_in_score;
    logic                      r_in_last;

    logic [POS_W-1:0]          r_pos;
    logic [MAX_TOP-1:0]        r_vld;
    logic signed [SCORE_W-1:0] r_best [MAX_TOP];
    logic [IDX_W-1:0]          r_idx  [MAX_TOP];

    logic                      w_adv;
    logic                      w_do_ins;
    logic [MAX_TOP-1:0]        w_ge;
    logic [MAX_TOP-1:0]        w_prev_ge;
    logic [MAX_TOP-1:0]        w_new_vld;
    logic signed [SCORE_W-1:0] w_new_score [MAX_TOP];
    logic [IDX_W-1:0]          w_new_idx   [MAX_TOP];

    // a last item waits until the result buffer can take the snapshot
    assign w_adv     = r_in_valid && (!r_in_last || i_load_ok);
    assign o_s_ready = !r_in_valid || w_adv;
    assign w_do_ins  = (r_pos < POS_W'(MAX_CLASSES));

    always_comb begin
        // entries that rank ahead of the new score form a prefix of the list
        for (int j = 0; j < MAX_TOP; j++) begin
            w_ge[j] = r_vld[j] && (r_in_score <= r_best[j]);
        end
        w_prev_ge = (w_ge << 1) | MAX_TOP'(1);
        for (int j = 0; j < MAX_TOP; j++) begin
            if (w_ge[j] || !w_do_ins) begin
                w_new_score[j] = r_best[j];
                w_new_idx[j]   = r_idx[j];
            end else if (w_prev_ge[j]) begin
                w_new_score[j] = r_in_score;
                w_new_idx[j]   = r_pos[IDX_W-1:0];
            end else begin
                // entry 0 always takes one of the branches above
                w_new_score[j] = r_best[(j > 0) ? j - 1 : 0];
                w_new_idx[j]   = r_idx[(j > 0) ? j - 1 : 0];
            end
        end
        w_new_vld = w_do_ins ? ((r_vld << 1) | MAX_TOP'(1)) : r_vld;
    end

    assign o_snap_valid = r_in_valid && r_in_last;
    assign o_snap_vld   = w_new_vld;
    assign o_snap_score = w_new_score;
    assign o_snap_idx   = w_new_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos      <= '0;
            r_vld      <= '0;
        end else begin
            if (o_s_ready) begin
                r_in_valid <= i_s_valid;
            end
            if (w_adv) begin
                if (r_in_last) begin
                    r_pos <= '0;
                    r_vld <= '0;
                end else begin
                    r_vld <= w_new_vld;
                    if (w_do_ins) begin
                        r_pos <= r_pos + POS_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_ready) begin
            r_in_score <= i_s_score;
            r_in_last  <= i_s_last;
        end
        if (w_adv && !r_in_last) begin
            r_best <= w_new_score;
            r_idx  <= w_new_idx;
        end
    end

    `TKSS_ASSERT(a_vld_prefix, ((r_vld + MAX_TOP'(1)) & r_vld) == '0)
    `TKSS_IMPLY_NEXT(a_clear_on_last, w_adv && r_in_last, r_vld == '0 && r_pos == '0)
    `TKSS_ASSERT(a_pos_bound, r_pos <= POS_W'(MAX_CLASSES))

endmodule

[sv/tkss_emitter.sv]
// ----------------------------------------------------------------------------
// tkss_emitter
// Holds the top_count register, a result buffer loaded with one vector's
// sorted entries, and the output register that sends them out best first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "top_k_score_selector_top_assert.svh"

module tkss_emitter #(
    parameter int MAX_TOP     = tkss_pkg::MAX_TOP_DEF,
    parameter int MAX_CLASSES = tkss_pkg::MAX_CLASSES_DEF,
    localparam int IDX_W      = $clog2(MAX_CLASSES)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [tkss_pkg::CFG_W-1:0]         i_cfg_wdata,
    // snapshot from the sorter
    output logic                               o_load_ok,
    input  logic                               i_snap_valid,
    input  logic [MAX_TOP-1:0]                 i_snap_vld,
    input  logic signed [tkss_pkg::SCORE_W-1:0] i_snap_score [MAX_TOP],
    input  logic [IDX_W-1:0]                   i_snap_idx   [MAX_TOP],
    // result stream
    output logic                               o_m_valid,
    input  logic                               i_m_ready,
    output logic [IDX_W-1:0]                   o_m_idx,
    output logic signed [tkss_pkg::SCORE_W-1:0] o_m_score,
    output logic                               o_m_last
);

    import tkss_pkg::*;

    logic [CFG_W-1:0]          r_top;
    logic [MAX_TOP-1:0]        r_em_vld;
    logic signed [SCORE_W-1:0] r_em_score [MAX_TOP];
    logic [IDX_W-1:0]          r_em_idx   [MAX_TOP];

    logic                      r_out_valid;
    logic [IDX_W-1:0]          r_out_idx;
    logic signed [SCORE_W-1:0] r_out_score;
    logic                      r_out_last;

    logic                      w_pop;
    logic                      w_load;
    logic [MAX_TOP-1:0]        w_rest_vld;
    logic [MAX_TOP-1:0]        w_kmask;

    // top_count of zero acts as one; values above MAX_TOP fall off the mask
    always_comb begin
        for (int j = 0; j < MAX_TOP; j++) begin
            w_kmask[j] = (j == 0) || (j < int'(r_top));
        end
    end

    assign w_rest_vld = r_em_vld >> 1;
    assign w_pop      = r_em_vld[0] && (!r_out_valid || i_m_ready);
    // free now, or the last buffered entry leaves this cycle
    assign o_load_ok  = !r_em_vld[0] || (w_pop && !w_rest_vld[0]);
    assign w_load     = i_snap_valid && o_load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= TOP_COUNT_RST;
            r_em_vld    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_top <= i_cfg_wdata;
            end
            if (w_load) begin
                r_em_vld <= i_snap_vld & w_kmask;
            end else if (w_pop) begin
                r_em_vld <= w_rest_vld;
            end
            if (w_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_em_score <= i_snap_score;
            r_em_idx   <= i_snap_idx;
        end else if (w_pop) begin
            for (int j = 0; j < MAX_TOP - 1; j++) begin
                r_em_score[j] <= r_em_score[j+1];
                r_em_idx[j]   <= r_em_idx[j+1];
            end
        end
        if (w_pop) begin
            r_out_idx   <= r_em_idx[0];
            r_out_score <= r_em_score[0];
            r_out_last  <= !w_rest_vld[0];
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_idx   = r_out_idx;
    assign o_m_score = r_out_score;
    assign o_m_last  = r_out_last;

    `TKSS_ASSERT(a_em_prefix, ((r_em_vld + MAX_TOP'(1)) & r_em_vld) == '0)
    `TKSS_IMPLY(a_more_queued, r_out_valid && !r_out_last, r_em_vld[0])
    `TKSS_IMPLY(a_snap_nonempty, i_snap_valid, i_snap_vld[0])

endmodule

[sv/top_k_score_selector_top.sv]
// ----------------------------------------------------------------------------
// top_k_score_selector_top
// Streaming top-k selection over a vector of class scores.
// ----------------------------------------------------------------------------
// Scores (signed Q16.16) enter one per cycle on the slave stream while tready
// is high, tlast marking the last score of a vector; a score's position in
// the vector is its class index, and scores past MAX_CLASSES are not ranked.
// Every score is inserted into a sorted list of MAX_TOP entries by one
// parallel compare, so the input takes an item every cycle unless a last
// item waits. At the end of a vector the best min(top_count, received)
// entries, top_count zero counting as one and capped at MAX_TOP, are copied
// to a result buffer and sent best first, one per cycle while the receiver
// is ready, ties to the lower index, tlast on the final one. A score enters
// the sorted list from the input register. A last item waits only while the
// result buffer still holds entries of the previous vector beyond the one
// leaving that cycle. top_count resets to 5; write it only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module top_k_score_selector_top #(
    parameter int  MAX_TOP     = tkss_pkg::MAX_TOP_DEF,
    parameter int  MAX_CLASSES = tkss_pkg::MAX_CLASSES_DEF,
    localparam int IDX_W       = $clog2(MAX_CLASSES),
    localparam int OUT_W       = ((IDX_W + tkss_pkg::SCORE_W + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // score stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [tkss_pkg::SCORE_W-1:0]  i_s_axis_tdata,  // [31:0] score
    input  logic                          i_s_axis_tlast,  // end_of_vector
    // result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [OUT_W-1:0]              o_m_axis_tdata,  // class_index, class_score, zero pad
    output logic                          o_m_axis_tlast,  // final_result
    // configuration: top_count
    input  logic                          i_cfg_we,
    input  logic [tkss_pkg::CFG_W-1:0]    i_cfg_wdata
);

    import tkss_pkg::*;

    logic                      w_load_ok;
    logic                      w_snap_valid;
    logic [MAX_TOP-1:0]        w_snap_vld;
    logic signed [SCORE_W-1:0] w_snap_score [MAX_TOP];
    logic [IDX_W-1:0]          w_snap_idx   [MAX_TOP];
    logic [IDX_W-1:0]          w_m_idx;
    logic signed [SCORE_W-1:0] w_m_score;

    tkss_sorter #(
        .MAX_TOP     (MAX_TOP),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_sorter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (i_s_axis_tvalid),
        .o_s_ready    (o_s_axis_tready),
        .i_s_score    (i_s_axis_tdata),
        .i_s_last     (i_s_axis_tlast),
        .i_load_ok    (w_load_ok),
        .o_snap_valid (w_snap_valid),
        .o_snap_vld   (w_snap_vld),
        .o_snap_score (w_snap_score),
        .o_snap_idx   (w_snap_idx)
    );

    tkss_emitter #(
        .MAX_TOP     (MAX_TOP),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_load_ok    (w_load_ok),
        .i_snap_valid (w_snap_valid),
        .i_snap_vld   (w_snap_vld),
        .i_snap_score (w_snap_score),
        .i_snap_idx   (w_snap_idx),
        .o_m_valid    (o_m_axis_tvalid),
        .i_m_ready    (i_m_axis_tready),
        .o_m_idx      (w_m_idx),
        .o_m_score    (w_m_score),
        .o_m_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OUT_W'({w_m_score, w_m_idx});

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the top-k score selector. A directed table covers
// the score extremes, ties, short vectors and the clamped top_count values.
// Random vectors follow under several idle/stall mixes, with one long
// receiver hold-off. Every accepted result is checked against a local
// ranking model or a typed result from the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_TOP     = tkss_pkg::MAX_TOP_DEF;
    localparam int MAX_CLASSES = tkss_pkg::MAX_CLASSES_DEF;
    localparam int IDX_W       = $clog2(MAX_CLASSES);
    localparam int SCORE_W     = tkss_pkg::SCORE_W;
    localparam int OUT_W       = ((IDX_W + SCORE_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 80;

    localparam logic [SCORE_W-1:0] SCORE_MAX = 32'h7FFF_FFFF;
    localparam logic [SCORE_W-1:0] SCORE_MIN = 32'h8000_0000;
    localparam logic [SCORE_W-1:0] SCORE_ONE = 32'h0001_0000;

    typedef struct packed {
        logic [IDX_W-1:0]          idx;
        logic signed [SCORE_W-1:0] score;
        logic                      fin;
    } ranked_entry_t;

    // one row: optional top_count write before the item, the item itself,
    // and a typed single result where it is obvious
    typedef struct packed {
        logic                      wr;
        logic [tkss_pkg::CFG_W-1:0] cfg;
        logic [SCORE_W-1:0]        score;
        logic                      last;
        logic                      typed;
        logic [IDX_W-1:0]          t_idx;
        logic [SCORE_W-1:0]        t_score;
    } stim_row_t;

    localparam int N_ROWS = 19;
    localparam stim_row_t DIRECTED_ROWS [0:N_ROWS-1] = '{
        // single item vectors after reset, fewer scores than top_count
        '{1'b0, 4'd0,  SCORE_MIN,     1'b1, 1'b1, 10'd0, SCORE_MIN},
        '{1'b0, 4'd0,  SCORE_MAX,     1'b1, 1'b1, 10'd0, SCORE_MAX},
        // top_count zero acts as one
        '{1'b1, 4'd0,  32'h0000_0005, 1'b0, 1'b0, 10'd0, 32'd0},
        '{1'b0, 4'd0,  SCORE_MAX,     1'b0, 1'b0, 10'd0, 32'd0},
        '{1'b0, 4'd0,  SCORE_MIN,     1'b1, 1'b1, 10'd1, SCORE_MAX},
        // top_count above the limit, nine equal scores
        '{1'b1, 4'd15, SCORE_ONE,     1'b0, 1'b0, 10'd0, 32'd0},
        '{1'b0, 4'd0,  SCORE_ONE,     1'b0, 1'b0, 10'd0, 32'd0},
        '{1'b0, 4'd0,  SCORE_ONE,     1'b0, 1'b0, 10'd0, 32'd0},
        '{1'b0, 4'd0,  SCORE_ONE,     1'b0, 1'b0, 10'd0, 32'd0},
        '{1'b0, 4'd0,  SCORE_ONE,     1'b0, 1'b0, 10'd0, 32'd0},
        '{1'b0, 4'd0,  SCORE_ONE,     1'b0, 1'b0, 10'd0, 32'd0},
        '{1'b0, 4'd0,  SCORE_ONE,     1'b0, 1'b0, 10'd0, 32'd0},
        '{1'b0, 4'd0,  SCORE_ONE,     1'b0, 1'b0, 10'd0, 32'd0},
        '{1'b0, 4'd0,  SCORE_ONE,     1'b1, 1'b0, 10'd0, 32'd0},
        // full top_count, short vector
        '{1'b1, 4'd8,  32'hFFFF_0000, 1'b0, 1'b0, 10'd0, 32'd0},
        '{1'b0, 4'd0,  32'h0000_8000, 1'b0, 1'b0, 10'd0, 32'd0},
        '{1'b0, 4'd0,  SCORE_ONE,     1'b1, 1'b0, 10'd0, 32'd0},
        // tie goes to the lower index
        '{1'b1, 4'd1,  32'hDEAD_BEEF, 1'b0, 1'b0, 10'd0, 32'd0},
        '{1'b0, 4'd0,  32'hDEAD_BEEF, 1'b1, 1'b1, 10'd0, 32'hDEAD_BEEF}
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_s_axis_tvalid;
    logic                        o_s_axis_tready;
    logic [SCORE_W-1:0]          i_s_axis_tdata;
    logic                        i_s_axis_tlast;
    logic                        o_m_axis_tvalid;
    logic                        i_m_axis_tready;
    logic [OUT_W-1:0]            o_m_axis_tdata;
    logic                        o_m_axis_tlast;
    logic                        i_cfg_we;
    logic [tkss_pkg::CFG_W-1:0]  i_cfg_wdata;

    // ranking model state
    logic signed [SCORE_W-1:0]   rank_score [MAX_TOP];
    logic [IDX_W-1:0]            rank_idx [MAX_TOP];
    int unsigned                 next_pos;
    int unsigned                 n_ranked;
    logic [tkss_pkg::CFG_W-1:0]  top_count;

    ranked_entry_t               pending_results [$];
    int                          error_count;
    int                          src_idle_pct;
    int                          dst_stall_pct;
    bit                          hold_request;
    int                          hold_left;

    top_k_score_selector_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [31:0] score
        .i_s_axis_tlast  (i_s_axis_tlast),   // end_of_vector
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [9:0] class_index, [41:10] class_score
        .o_m_axis_tlast  (o_m_axis_tlast),   // final_result
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Update the ranking with one accepted score; on end of vector queue the
    // best min(top_count, received) entries unless the row supplies its own.
    task automatic rank_update(input logic signed [SCORE_W-1:0] s, input logic last,
                               input bit push);
        int unsigned p;
        int unsigned j;
        int unsigned k;
        int unsigned n;
        ranked_entry_t e;
        if (next_pos < MAX_CLASSES) begin
            p = 0;
            while (p < n_ranked && p < MAX_TOP && s <= rank_score[p])
                p++;
            if (p < MAX_TOP) begin
                j = (n_ranked < MAX_TOP) ? n_ranked : MAX_TOP - 1;
                while (j > p) begin
                    rank_score[j] = rank_score[j-1];
                    rank_idx[j]   = rank_idx[j-1];
                    j--;
                end
                rank_score[p] = s;
                rank_idx[p]   = IDX_W'(next_pos);
                if (n_ranked < MAX_TOP)
                    n_ranked++;
            end
            next_pos++;
        end
        if (last) begin
            k = top_count;
            if (k < 1)
                k = 1;
            if (k > MAX_TOP)
                k = MAX_TOP;
            n = (n_ranked < k) ? n_ranked : k;
            if (push) begin
                for (int unsigned i = 0; i < n; i++) begin
                    e.idx   = rank_idx[i];
                    e.score = rank_score[i];
                    e.fin   = (i + 1 == n);
                    pending_results = {pending_results, e};
                end
            end
            next_pos = 0;
            n_ranked = 0;
        end
    endtask

    // Entered and left just after a falling edge; tvalid stays up on exit.
    task automatic score_item(input logic [SCORE_W-1:0] s, input logic last,
                              input logic typed = 1'b0,
                              input logic [IDX_W-1:0] t_idx = '0,
                              input logic [SCORE_W-1:0] t_score = '0);
        ranked_entry_t e;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        rank_update(s, last, !typed);
        if (typed && last) begin
            e.idx   = t_idx;
            e.score = t_score;
            e.fin   = 1'b1;
            pending_results = {pending_results, e};
        end
        @(negedge i_clk);
    endtask

    // Only while idle: all results in, plus a settling margin.
    task automatic write_top_count(input logic [tkss_pkg::CFG_W-1:0] v);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        top_count = v;
        i_cfg_we  <= 1'b0;
    endtask

    function automatic logic [SCORE_W-1:0] random_score(input int unsigned mode);
        logic [SCORE_W-1:0] s;
        case (mode)
            1: s = SCORE_W'($signed($urandom_range(0, 6)) - 3) << 16;
            2: begin
                case ($urandom_range(0, 4))
                    0: s = SCORE_MAX;
                    1: s = SCORE_MIN;
                    2: s = '0;
                    3: s = '1;
                    default: s = 32'd1;
                endcase
            end
            default: s = $urandom;
        endcase
        return s;
    endfunction

    task automatic send_vector(input int unsigned len, output int unsigned sent);
        int unsigned mode;
        mode = $urandom_range(0, 3);
        for (int unsigned i = 0; i < len; i++)
            score_item(random_score(mode), i == len - 1);
        sent = len;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        i_m_axis_tready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_axis_tready <= 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        ranked_entry_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t unexpected result: expected none, actual idx=%0d score=%h last=%b",
                         $time, o_m_axis_tdata[IDX_W-1:0],
                         o_m_axis_tdata[IDX_W +: SCORE_W], o_m_axis_tlast);
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[IDX_W-1:0] !== want.idx) begin
                    error_count++;
                    $display("%0t class_index mismatch: expected %0d actual %0d",
                             $time, want.idx, o_m_axis_tdata[IDX_W-1:0]);
                end
                if (o_m_axis_tdata[IDX_W +: SCORE_W] !== want.score) begin
                    error_count++;
                    $display("%0t class_score mismatch: expected %h actual %h",
                             $time, want.score, o_m_axis_tdata[IDX_W +: SCORE_W]);
                end
                if (o_m_axis_tlast !== want.fin) begin
                    error_count++;
                    $display("%0t final_result mismatch: expected %b actual %b",
                             $time, want.fin, o_m_axis_tlast);
                end
            end
        end
    end

    initial begin
        int cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int unsigned sent;
        int unsigned in_phase;
        int unsigned len;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        error_count     = 0;
        src_idle_pct    = 0;
        dst_stall_pct   = 0;
        hold_request    = 1'b0;
        next_pos        = 0;
        n_ranked        = 0;
        top_count       = tkss_pkg::TOP_COUNT_RST;
        for (int i = 0; i < MAX_TOP; i++) begin
            rank_score[i] = '0;
            rank_idx[i]   = '0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (DIRECTED_ROWS[r].wr)
                write_top_count(DIRECTED_ROWS[r].cfg);
            score_item(DIRECTED_ROWS[r].score, DIRECTED_ROWS[r].last,
                       DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].t_idx,
                       DIRECTED_ROWS[r].t_score);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1: begin src_idle_pct = 61; dst_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  dst_stall_pct = 61; end
                default: begin src_idle_pct = 7; dst_stall_pct = 7; end
            endcase
            write_top_count(ph == 0 ? 4'd15 : ph == 1 ? 4'd0 : 4'($urandom_range(0, 15)));
            if (ph == 0)
                hold_request = 1'b1;    // sender keeps going, block must back up
            in_phase = 0;
            while (in_phase < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0)
                    write_top_count(4'($urandom_range(0, 15)));
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24)
                                                  : $urandom_range(1, 8);
                send_vector(len, sent);
                in_phase += sent;
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/tkss_pkg.sv
sv/tkss_sorter.sv
sv/tkss_emitter.sv
sv/top_k_score_selector_top.sv
bench/testbench.sv
